// File: design/rpvg_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the
// regular polygon vertex generator. No dependencies.
package rpvg_pkg;

    localparam int MaxSides    = 12;
    localparam int CordicSteps = 18;
    localparam int NStages     = (CordicSteps > 32) ? 32 : CordicSteps;

    localparam int XW = 34;   // CORDIC x/y width, Q2.30 with headroom
    localparam int ZW = 33;   // CORDIC residual angle width

    // 360.0 in Q16.16 is Div45 << 19; quotients by 45 use a reciprocal multiply
    localparam int Div45     = 45;
    localparam int Recip45   = 23302;  // ceil(2^20 / 45), exact for inputs below 2^14
    localparam int Recip45Sh = 20;
    localparam int RotBias   = 4140;   // 92 * 45, keeps rotation >>> 19 non-negative
    localparam int BaseRound = 22;     // half of 360 deg after dropping 19 zero lsbs

    localparam logic signed [XW-1:0] GainQ30 = XW'(652032874);

    // atan(2^-i) as a fraction of a full turn, 2^32 = one turn
    function automatic logic [29:0] atan_turn(input int i);
        logic [29:0] v;
        case (i)
            0:  v = 30'h20000000;  1:  v = 30'h12E4051E;  2:  v = 30'h09FB385B;
            3:  v = 30'h051111D4;  4:  v = 30'h028B0D43;  5:  v = 30'h0145D7E1;
            6:  v = 30'h00A2F61E;  7:  v = 30'h00517C55;  8:  v = 30'h0028BE53;
            9:  v = 30'h00145F2F;  10: v = 30'h000A2F98;  11: v = 30'h000517CC;
            12: v = 30'h00028BE6;  13: v = 30'h000145F3;  14: v = 30'h0000A2FA;
            15: v = 30'h0000517D;  16: v = 30'h000028BE;  17: v = 30'h0000145F;
            18: v = 30'h00000A30;  19: v = 30'h00000518;  20: v = 30'h0000028C;
            21: v = 30'h00000146;  22: v = 30'h000000A3;  23: v = 30'h00000051;
            24: v = 30'h00000029;  25: v = 30'h00000014;  26: v = 30'h0000000A;
            27: v = 30'h00000005;  28: v = 30'h00000003;  29: v = 30'h00000001;
            30: v = 30'h00000001;
            default: v = 30'h00000000;
        endcase
        return v;
    endfunction

    // per-vertex tag travelling down the pipeline
    typedef struct packed {
        logic [31:0] diam;
        logic [5:0]  idx;
        logic        last;
        logic        bad;
    } t_tag;

    typedef struct packed {
        logic        start;
        logic [24:0] rem_init;
        logic [32:0] num;       // left aligned, msb first
        logic [5:0]  nbits;
        logic [24:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
        logic [24:0] rem;
    } t_div_rsp;

endpackage

// File: design/rpvg_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on rpvg_pkg.
module rpvg_div import rpvg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic        r_busy, r_done;
    logic [5:0]  r_cnt;
    logic [24:0] r_rem, r_div;
    logic [32:0] r_num;
    logic [31:0] r_q;

    logic [25:0] w_trial, w_diff;
    logic        w_ge;

    always_comb begin
        w_trial = {r_rem, r_num[32]};
        w_ge    = (w_trial >= {1'b0, r_div});
        w_diff  = w_ge ? (w_trial - {1'b0, r_div}) : w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_req.start) begin
            r_rem <= i_req.rem_init;
            r_num <= i_req.num;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_diff[24:0];
            r_num <= {r_num[31:0], 1'b0};
            r_q   <= {r_q[30:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;
    assign o_rsp.rem  = r_rem;

endmodule

// File: design/rpvg_cordic.sv
// Fully pipelined rotation-mode CORDIC, one stage per iteration, plus
// half-turn folding on entry and sign restore on exit. Depends on rpvg_pkg.
module rpvg_cordic import rpvg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [31:0]          i_angle,
    input  t_tag                 i_tag,
    output logic                 o_valid,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output t_tag                 o_tag
);

    logic signed [XW-1:0] r_x [0:NStages];
    logic signed [XW-1:0] r_y [0:NStages];
    logic signed [ZW-1:0] r_z [0:NStages];
    logic                 r_f [0:NStages];
    logic                 r_v [0:NStages];
    t_tag                 r_t [0:NStages];

    logic                 r_ov;
    logic signed [XW-1:0] r_ox, r_oy;
    t_tag                 r_ot;

    logic        w_flip;
    logic [31:0] w_a;

    // quadrants 1 and 2 fold by a half turn
    assign w_flip = i_angle[31] ^ i_angle[30];
    assign w_a    = w_flip ? (i_angle ^ 32'h8000_0000) : i_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NStages; s++) r_v[s] <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 0; s < NStages; s++) r_v[s+1] <= r_v[s];
            r_ov <= r_v[NStages];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= GainQ30;
            r_y[0] <= '0;
            r_z[0] <= $signed({w_a[31], w_a});
            r_f[0] <= w_flip;
            r_t[0] <= i_tag;
            for (int s = 0; s < NStages; s++) begin
                if (r_z[s] >= 0) begin
                    r_x[s+1] <= r_x[s] - (r_y[s] >>> s);
                    r_y[s+1] <= r_y[s] + (r_x[s] >>> s);
                    r_z[s+1] <= r_z[s] - $signed({3'b000, atan_turn(s)});
                end else begin
                    r_x[s+1] <= r_x[s] + (r_y[s] >>> s);
                    r_y[s+1] <= r_y[s] - (r_x[s] >>> s);
                    r_z[s+1] <= r_z[s] + $signed({3'b000, atan_turn(s)});
                end
                r_f[s+1] <= r_f[s];
                r_t[s+1] <= r_t[s];
            end
            r_ox <= r_f[NStages] ? -r_x[NStages] : r_x[NStages];
            r_oy <= r_f[NStages] ? -r_y[NStages] : r_y[NStages];
            r_ot <= r_t[NStages];
        end
    end

    assign o_valid = r_ov;
    assign o_x     = r_ox;
    assign o_y     = r_oy;
    assign o_tag   = r_ot;

endmodule

// File: design/rpvg_scale.sv
// Radius scaling: multiply stage, then rounding, saturation and the
// output register. Depends on rpvg_pkg.
module rpvg_scale import rpvg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  t_tag                 i_tag,
    output logic                 o_valid,
    output logic [31:0]          o_x,
    output logic [31:0]          o_y,
    output logic [5:0]           o_idx,
    output logic                 o_last,
    output logic                 o_bad
);

    localparam int PW = XW + 33;
    localparam logic signed [PW-1:0] SatMax = PW'(64'd2147483647);
    localparam logic signed [PW-1:0] SatMin = ~SatMax;
    localparam logic signed [PW-1:0] Half   = PW'(64'd1073741824);

    function automatic logic [31:0] round_sat(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] v;
        v = (p + Half) >>> 31;
        if (v > SatMax)      v = SatMax;
        else if (v < SatMin) v = SatMin;
        return v[31:0];
    endfunction

    logic                 r_mv;
    logic signed [PW-1:0] r_px, r_py;
    t_tag                 r_mt;

    logic        r_ov;
    logic [31:0] r_ox, r_oy;
    logic [5:0]  r_oidx;
    logic        r_olast, r_obad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_mv <= i_valid;
            r_ov <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px    <= $signed({1'b0, i_tag.diam}) * i_x;
            r_py    <= $signed({1'b0, i_tag.diam}) * i_y;
            r_mt    <= i_tag;
            r_ox    <= r_mt.bad ? 32'd0 : round_sat(r_px);
            r_oy    <= r_mt.bad ? 32'd0 : round_sat(r_py);
            r_oidx  <= r_mt.idx;
            r_olast <= r_mt.last;
            r_obad  <= r_mt.bad;
        end
    end

    assign o_valid = r_ov;
    assign o_x     = r_ox;
    assign o_y     = r_oy;
    assign o_idx   = r_oidx;
    assign o_last  = r_olast;
    assign o_bad   = r_obad;

endmodule

// File: design/regular_polygon_vertex_generator.sv
// Top level of the regular polygon vertex generator: setup sequencer,
// serial divider, CORDIC pipeline and scaling stage. Depends on rpvg_pkg.
//
//  channel | dir | tdata fields (lsb up)                  | side band
//  s_axis  | in  | diameter 32, sides 6, rotation 32, pad | -
//  m_axis  | out | vertex_x 32, vertex_y 32, index 6, pad | tlast=last, tuser=bad_sides
//
// Sequence: one polygon transaction is taken when the sequencer is idle. Setup
// reduces the rotation modulo 360 (ST_MOD), forms the base angle as four
// radix-256 digits of a division by 45 (ST_BASE), then runs the serial
// divider for the step angle (ST_STEP). Vertices then issue one per cycle
// while m_axis is not stalled; the input stays held off until the last
// vertex, or the single result for a bad side count, has issued. Results
// pass the issue, CORDIC and scaling registers. Reset is synchronous and
// clears the sequencer and all valid bits. A stall on m_axis freezes the
// whole pipeline and vertex issue; nothing is lost or repeated.
module regular_polygon_vertex_generator import rpvg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,   // diameter, sides, rotation, pad
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // vertex_x, vertex_y, vertex_index, pad
    output logic        o_m_axis_tlast,
    output logic        o_m_axis_tuser    // bad_sides
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MOD, ST_BASE, ST_STEP, ST_EMIT, ST_BAD
    } t_state;

    // floor(v / 45) for v below 256 * 45 = 11520, where the quotient fits 8 bits
    function automatic logic [7:0] div45(input logic [13:0] v);
        logic [28:0] p;
        p = {15'd0, v} * 29'(Recip45);
        return p[Recip45Sh +: 8];
    endfunction

    t_state      r_state;
    logic [5:0]  r_vertex_counter, r_sides_reg;
    logic [31:0] r_current_angle, r_step_angle, r_radius_reg;
    logic [13:0] r_turns;      // rotation >>> 19, biased positive
    logic [5:0]  r_rem45;      // running remainder of the division by 45
    logic [31:0] r_dividend, r_quo;
    logic [1:0]  r_digit;
    t_div_req    r_req;
    t_div_rsp    w_rsp;

    // issue register feeding the CORDIC
    logic        r_iv;
    logic [31:0] r_iang;
    t_tag        r_itag;

    logic [31:0] w_diam, w_rot;
    logic [5:0]  w_sides;
    logic        w_bad_in, w_en, w_last_vtx, w_issue, w_kick;
    logic [7:0]  w_turn_q, w_dig_q;
    logic [13:0] w_dig_num;

    assign w_diam   = i_s_axis_tdata[31:0];
    assign w_sides  = i_s_axis_tdata[37:32];
    assign w_rot    = i_s_axis_tdata[69:38];
    assign w_bad_in = (w_sides < 6'd3) || (w_sides > 6'(MaxSides));

    // 360 deg = 45 << 19, so only the bits from bit 19 up need reducing mod 45
    assign w_turn_q  = div45(r_turns);
    // base angle digit: (remainder, next byte) / 45
    assign w_dig_num = {r_rem45, r_dividend[31:24]};
    assign w_dig_q   = div45(w_dig_num);

    assign w_last_vtx = (r_vertex_counter == (r_sides_reg - 6'd1));

    // pipeline advances whenever the output register is free or being taken
    assign w_en    = !o_m_axis_tvalid || i_m_axis_tready;
    assign w_issue = (r_state == ST_EMIT) || (r_state == ST_BAD);
    assign w_kick  = (r_state == ST_BASE) && (r_digit == 2'd3);

    assign o_s_axis_tready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_vertex_counter <= '0;
            r_current_angle  <= '0;
            r_step_angle     <= '0;
            r_radius_reg     <= '0;
            r_sides_reg      <= '0;
            r_turns          <= '0;
            r_rem45          <= '0;
            r_dividend       <= '0;
            r_quo            <= '0;
            r_digit          <= '0;
            r_req            <= '0;
            r_iv             <= 1'b0;
            r_iang           <= '0;
            r_itag           <= '0;
        end else begin
            r_req.start <= w_kick;
            if (w_en) begin
                r_iv <= w_issue;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_sides_reg <= w_sides;
                        if (w_bad_in) begin
                            r_vertex_counter <= '0;
                            r_state          <= ST_BAD;
                        end else begin
                            r_radius_reg <= w_diam;
                            r_turns      <= {w_rot[31], w_rot[31:19]} + 14'(RotBias);
                            // m * 2^13 + 22 below the top digit
                            r_dividend   <= {w_rot[18:0], 13'(BaseRound)};
                            r_state      <= ST_MOD;
                        end
                    end
                end
                ST_MOD: begin
                    r_rem45 <= 6'(r_turns - {6'd0, w_turn_q} * 14'(Div45));
                    r_digit <= '0;
                    r_state <= ST_BASE;
                end
                ST_BASE: begin
                    r_rem45    <= 6'(w_dig_num - {6'd0, w_dig_q} * 14'(Div45));
                    r_quo      <= {r_quo[23:0], w_dig_q};
                    r_dividend <= {r_dividend[23:0], 8'd0};
                    r_digit    <= r_digit + 2'd1;
                    if (r_digit == 2'd3) begin
                        r_current_angle <= {r_quo[23:0], w_dig_q};
                        // (2^32 + n/2) / n
                        r_req.rem_init <= '0;
                        r_req.num      <= {1'b1, 26'd0, 1'b0, r_sides_reg[5:1]};
                        r_req.nbits    <= 6'd33;
                        r_req.divisor  <= {19'd0, r_sides_reg};
                        r_state        <= ST_STEP;
                    end
                end
                ST_STEP: begin
                    if (w_rsp.done) begin
                        r_step_angle     <= w_rsp.quo;
                        r_vertex_counter <= '0;
                        r_state          <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_en) begin
                        r_iang           <= r_current_angle;
                        r_itag.diam      <= r_radius_reg;
                        r_itag.idx       <= r_vertex_counter;
                        r_itag.last      <= w_last_vtx;
                        r_itag.bad       <= 1'b0;
                        r_current_angle  <= r_current_angle + r_step_angle;
                        r_vertex_counter <= r_vertex_counter + 6'd1;
                        if (w_last_vtx) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_BAD: begin
                    if (w_en) begin
                        r_iang      <= '0;
                        r_itag.diam <= '0;
                        r_itag.idx  <= '0;
                        r_itag.last <= 1'b1;
                        r_itag.bad  <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    rpvg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (w_rsp)
    );

    logic                 w_cv;
    logic signed [XW-1:0] w_cx, w_cy;
    t_tag                 w_ctag;

    rpvg_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_iv),
        .i_angle (r_iang),
        .i_tag   (r_itag),
        .o_valid (w_cv),
        .o_x     (w_cx),
        .o_y     (w_cy),
        .o_tag   (w_ctag)
    );

    logic [31:0] w_ox, w_oy;
    logic [5:0]  w_oidx;

    rpvg_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cv),
        .i_x     (w_cx),
        .i_y     (w_cy),
        .i_tag   (w_ctag),
        .o_valid (o_m_axis_tvalid),
        .o_x     (w_ox),
        .o_y     (w_oy),
        .o_idx   (w_oidx),
        .o_last  (o_m_axis_tlast),
        .o_bad   (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {2'b00, w_oidx, w_oy, w_ox};

    // a flagged result always closes its polygon
    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> o_m_axis_tlast)
        else $error("bad_sides result without tlast");

    // an accepted polygon leaves the sequencer busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("sequencer idle right after accepting a transaction");

    // vertex counter stays inside the polygon while emitting
    a_counter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_vertex_counter < r_sides_reg))
        else $error("vertex counter beyond side count");

    // divider only finishes during setup
    a_div_done_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == ST_MOD || r_state == ST_BASE || r_state == ST_STEP))
        else $error("divider result outside setup");

endmodule
